// ===== rtl/dprs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprs_pkg
// Shared types and constants for the display page refresh sequencer.
// ----------------------------------------------------------------------------
package dprs_pkg;

    localparam int unsigned PAGE_COUNT_DEF = 8;
    localparam int unsigned PAGE_W         = 4;
    localparam int unsigned WAIT_W         = 10;
    localparam int unsigned VAL_W          = 8;

    localparam logic [WAIT_W-1:0] TIMEOUT_RST = 10'd700;

    localparam logic [VAL_W-1:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [VAL_W-1:0] CMD_COL_LOW   = 8'h00;
    localparam logic [VAL_W-1:0] CMD_COL_HIGH  = 8'h10;

    localparam logic [VAL_W-1:0] ERR_PREP_TIMEOUT = 8'd0;
    localparam logic [VAL_W-1:0] ERR_XFER_TIMEOUT = 8'd1;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_POLL    = 2'd1,
        KIND_FORCE   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_CMD    = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_ERR    = 2'd2,
        ACT_STATUS = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PREP = 3'b010,
        PH_WAIT = 3'b100
    } phase_t;

    // position within a four-beat page setup burst
    typedef enum logic [1:0] {
        POS_PAGE = 2'd0,
        POS_COLL = 2'd1,
        POS_COLH = 2'd2,
        POS_DATA = 2'd3
    } burst_pos_t;

endpackage

// ===== rtl/display_page_refresh_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_page_refresh_sequencer_core
// Page refresh sequencer: takes request, poll and force-idle items, updates
// the refresh state and emits status, command, data or error beats.
// ----------------------------------------------------------------------------
// latency: first result beat is valid the cycle after the input beat is taken
// throughput: one input per cycle for single-result items while the result side
//   does not stall; a poll that sets up a page gives four beats, and the next input
//   is stalled until the last of them is taken
// reset: state returns to idle with done set, timeout limit goes to 700
module display_page_refresh_sequencer_core
    import dprs_pkg::*;
#(
    parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              link_busy,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        action,
    output logic [VAL_W-1:0]  value,
    output logic              update_done,
    output logic              request_pending,
    output logic              last,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WAIT_W-1:0] cfg_data
);

    // refresh state
    phase_t              phase_reg, phase_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                done_reg, done_next;
    logic                start_reg, start_next;
    logic                pend_reg, pend_next;
    logic [WAIT_W-1:0]   limit_reg;

    // result bundle
    logic                bnd_valid_reg, bnd_valid_next;
    logic                bnd_multi_reg, bnd_multi_next;
    burst_pos_t          bnd_pos_reg, bnd_pos_next;
    action_t             bnd_act_reg, res_act;
    logic [VAL_W-1:0]    bnd_val_reg, res_val;
    logic                res_multi;

    logic                in_take;
    logic                out_take;
    logic [WAIT_W-1:0]   wait_inc;
    logic [PAGE_W:0]     page_inc;

    assign cfg_ready = 1'b1;

    assign out_valid = bnd_valid_reg;
    assign out_take  = bnd_valid_reg && !out_stall;
    assign last      = !bnd_multi_reg || (bnd_pos_reg == POS_DATA);
    assign in_stall  = bnd_valid_reg && !(out_take && last);
    assign in_take   = in_valid && !in_stall;

    assign update_done     = done_reg;
    assign request_pending = pend_reg;

    always_comb
    begin
        if (bnd_multi_reg)
        begin
            case (bnd_pos_reg)
                POS_PAGE:
                begin
                    action = ACT_CMD;
                    value  = CMD_PAGE_BASE + VAL_W'(page_reg);
                end
                POS_COLL:
                begin
                    action = ACT_CMD;
                    value  = CMD_COL_LOW;
                end
                POS_COLH:
                begin
                    action = ACT_CMD;
                    value  = CMD_COL_HIGH;
                end
                default:
                begin
                    action = ACT_DATA;
                    value  = VAL_W'(page_reg);
                end
            endcase
        end
        else
        begin
            action = bnd_act_reg;
            value  = bnd_val_reg;
        end
    end

    assign wait_inc = wait_reg + WAIT_W'(1);
    assign page_inc = {1'b0, page_reg} + (PAGE_W+1)'(1);

    // one pass of the sequencer for the accepted beat
    always_comb
    begin
        phase_next = phase_reg;
        page_next  = page_reg;
        wait_next  = wait_reg;
        done_next  = done_reg;
        start_next = start_reg;
        pend_next  = pend_reg;
        res_act    = ACT_STATUS;
        res_val    = '0;
        res_multi  = 1'b0;

        case (kind_t'(kind))
            KIND_REQUEST:
            begin
                if (done_reg && !start_reg)
                    start_next = 1'b1;
                else
                    pend_next = 1'b1;
            end
            KIND_POLL:
            begin
                // promote a queued request
                if (pend_reg && done_reg && !start_reg)
                begin
                    pend_next  = 1'b0;
                    start_next = 1'b1;
                end

                if (phase_reg != PH_PREP && phase_reg != PH_WAIT)
                begin
                    phase_next = PH_IDLE;
                    if (start_next)
                    begin
                        done_next = 1'b0;
                        wait_next = '0;
                        page_next = '0;
                        if (!link_busy)
                        begin
                            res_multi  = 1'b1;
                            phase_next = PH_WAIT;
                        end
                        else if (WAIT_W'(1) >= limit_reg)
                        begin
                            wait_next  = WAIT_W'(1);
                            done_next  = 1'b1;
                            start_next = 1'b0;
                            phase_next = PH_IDLE;
                            res_act    = ACT_ERR;
                            res_val    = ERR_PREP_TIMEOUT;
                        end
                        else
                        begin
                            wait_next  = WAIT_W'(1);
                            phase_next = PH_PREP;
                        end
                    end
                end
                else if (phase_reg == PH_PREP)
                begin
                    if (!link_busy)
                    begin
                        res_multi  = 1'b1;
                        phase_next = PH_WAIT;
                        wait_next  = '0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= limit_reg)
                        begin
                            done_next  = 1'b1;
                            start_next = 1'b0;
                            phase_next = PH_IDLE;
                            res_act    = ACT_ERR;
                            res_val    = ERR_PREP_TIMEOUT;
                        end
                    end
                end
                else
                begin
                    if (!link_busy)
                    begin
                        page_next = page_inc[PAGE_W-1:0];
                        if (page_inc < (PAGE_W+1)'(PAGE_COUNT))
                        begin
                            phase_next = PH_PREP;
                            wait_next  = '0;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_IDLE;
                            start_next = pend_next;
                            pend_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= limit_reg)
                        begin
                            done_next  = 1'b1;
                            start_next = 1'b0;
                            phase_next = PH_IDLE;
                            res_act    = ACT_ERR;
                            res_val    = ERR_XFER_TIMEOUT;
                        end
                    end
                end
            end
            KIND_FORCE:
            begin
                phase_next = PH_IDLE;
                page_next  = '0;
                wait_next  = '0;
                done_next  = 1'b1;
                start_next = 1'b0;
                pend_next  = 1'b0;
            end
            default:
            begin
                res_act = ACT_STATUS;
            end
        endcase
    end

    always_comb
    begin
        bnd_valid_next = bnd_valid_reg;
        bnd_multi_next = bnd_multi_reg;
        bnd_pos_next   = bnd_pos_reg;
        if (in_take)
        begin
            bnd_valid_next = 1'b1;
            bnd_multi_next = res_multi;
            bnd_pos_next   = POS_PAGE;
        end
        else if (out_take)
        begin
            if (last)
            begin
                bnd_valid_next = 1'b0;
                bnd_pos_next   = POS_PAGE;
            end
            else
                bnd_pos_next = burst_pos_t'(bnd_pos_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            page_reg      <= '0;
            wait_reg      <= '0;
            done_reg      <= 1'b1;
            start_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            limit_reg     <= TIMEOUT_RST;
            bnd_valid_reg <= 1'b0;
            bnd_multi_reg <= 1'b0;
            bnd_pos_reg   <= POS_PAGE;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
                page_reg  <= page_next;
                wait_reg  <= wait_next;
                done_reg  <= done_next;
                start_reg <= start_next;
                pend_reg  <= pend_next;
            end
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            bnd_valid_reg <= bnd_valid_next;
            bnd_multi_reg <= bnd_multi_next;
            bnd_pos_reg   <= bnd_pos_next;
        end
    end

    // payload of the single-result bundle
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            bnd_act_reg <= res_act;
            bnd_val_reg <= res_val;
        end
    end

    a_done_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (phase_reg == PH_IDLE))
        else $error("refresh done while phase is not idle");

    a_busy_means_active: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> (phase_reg == PH_PREP || phase_reg == PH_WAIT))
        else $error("refresh running while phase is idle");

    a_pos_only_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (bnd_pos_reg != POS_PAGE) |-> (bnd_valid_reg && bnd_multi_reg))
        else $error("burst position advanced outside a burst");

    a_take_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (out_valid && bnd_pos_reg == POS_PAGE))
        else $error("accepted item did not produce a first result beat");

endmodule

// ===== test/tb_display_page_refresh_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_display_page_refresh_sequencer_core
// Self-checking bench for the page refresh sequencer. Request, poll,
// force-idle and unused-kind beats go in with random gaps while the result side
// stalls at random. A scoreboard predicts every status, command, data-start and
// error beat and compares each one with what the block returns.
// ----------------------------------------------------------------------------
module tb_display_page_refresh_sequencer_core;
    import dprs_pkg::*;

    localparam int unsigned PAGES      = PAGE_COUNT_DEF;
    localparam int          QUIET_MAX  = 1000;
    localparam int          HOLD_BEATS = 40;
    localparam int          RAND_ITEMS = 24;

    typedef struct packed {
        logic [1:0]       act;
        logic [VAL_W-1:0] val;
        logic             done;
        logic             pend;
        logic             last;
    } refresh_beat_t;

    // predicts the beats of every accepted input and checks returned beats
    class refresh_scoreboard;
        logic [WAIT_W-1:0] limit;
        phase_t            ph;
        logic [PAGE_W-1:0] page;
        logic [WAIT_W-1:0] waits;
        logic              done_f;
        logic              start_f;
        logic              pend_f;
        refresh_beat_t     expq[$];
        int                errors;
        int                n_in;
        int                n_out;
        int                n_timeouts;
        int                n_refreshes;

        function new();
            limit       = TIMEOUT_RST;
            errors      = 0;
            n_in        = 0;
            n_out       = 0;
            n_timeouts  = 0;
            n_refreshes = 0;
            clear_state();
        endfunction

        function void clear_state();
            ph      = PH_IDLE;
            page    = '0;
            waits   = '0;
            done_f  = 1'b1;
            start_f = 1'b0;
            pend_f  = 1'b0;
        endfunction

        function void set_limit(logic [WAIT_W-1:0] v);
            limit = v;
        endfunction

        function int count();
            return expq.size();
        endfunction

        function void note_input(kind_t k, logic busy);
            action_t          act[4];
            logic [VAL_W-1:0] val[4];
            logic [PAGE_W:0]  nxt;
            refresh_beat_t    b;
            int               n;
            n      = 1;
            act[0] = ACT_STATUS;
            val[0] = '0;
            n_in++;
            case (k)
                KIND_REQUEST: begin
                    if (done_f && !start_f)
                        start_f = 1'b1;
                    else
                        pend_f = 1'b1;
                end
                KIND_POLL: begin
                    if (pend_f && done_f && !start_f) begin
                        pend_f  = 1'b0;
                        start_f = 1'b1;
                    end
                    // a start kicks off page 0 on the same poll
                    if (ph == PH_IDLE && start_f) begin
                        page   = '0;
                        done_f = 1'b0;
                        waits  = '0;
                        ph     = PH_PREP;
                    end
                    if (ph == PH_PREP && !busy) begin
                        act[0] = ACT_CMD;
                        val[0] = CMD_PAGE_BASE + page;
                        act[1] = ACT_CMD;
                        val[1] = CMD_COL_LOW;
                        act[2] = ACT_CMD;
                        val[2] = CMD_COL_HIGH;
                        act[3] = ACT_DATA;
                        val[3] = page;
                        n      = 4;
                        ph     = PH_WAIT;
                        waits  = '0;
                    end else if (ph != PH_IDLE && busy) begin
                        waits = waits + 1'b1;
                        if (waits >= limit) begin
                            act[0]  = ACT_ERR;
                            val[0]  = (ph == PH_PREP) ? ERR_PREP_TIMEOUT : ERR_XFER_TIMEOUT;
                            done_f  = 1'b1;
                            start_f = 1'b0;
                            ph      = PH_IDLE;
                            n_timeouts++;
                        end
                    end else if (ph == PH_WAIT) begin
                        nxt  = {1'b0, page} + 1'b1;
                        page = nxt[PAGE_W-1:0];
                        if (nxt < PAGES) begin
                            ph    = PH_PREP;
                            waits = '0;
                        end else begin
                            done_f  = 1'b1;
                            start_f = 1'b0;
                            ph      = PH_IDLE;
                            n_refreshes++;
                            if (pend_f) begin
                                pend_f  = 1'b0;
                                start_f = 1'b1;
                            end
                        end
                    end
                end
                KIND_FORCE: clear_state();
                default: ;
            endcase
            for (int i = 0; i < n; i++) begin
                b.act  = act[i];
                b.val  = val[i];
                b.done = done_f;
                b.pend = pend_f;
                b.last = (i == n - 1);
                expq.push_back(b);
            end
        endfunction

        function int field_diff(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(logic [1:0] a, logic [VAL_W-1:0] v, logic d, logic p,
                                   logic l);
            refresh_beat_t e;
            int            bad;
            n_out++;
            if (expq.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual action %0d value %0h",
                         $time, a, v);
                errors++;
                return;
            end
            e   = expq.pop_front();
            bad = field_diff("action", e.act, a)
                + field_diff("value", e.val, v)
                + field_diff("update_done", e.done, d)
                + field_diff("request_pending", e.pend, p)
                + field_diff("last", e.last, l);
            if (bad != 0)
                errors++;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic              link_busy;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        action;
    logic [VAL_W-1:0]  value;
    logic              update_done;
    logic              request_pending;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WAIT_W-1:0] cfg_data;

    refresh_scoreboard sb;
    int                in_gap_pct;
    int                out_gap_pct;
    bit                hold_go;
    int                quiet;
    int                n_settings;

    display_page_refresh_sequencer_core #(
        .PAGE_COUNT (PAGES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .link_busy       (link_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .value           (value),
        .update_done     (update_done),
        .request_pending (request_pending),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result side: random stalls, plus one long hold when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_BEATS) @(negedge clk);
            end
            out_stall = ($urandom_range(0, 99) < out_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(action, value, update_done, request_pending, last);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input kind_t k, input logic busy);
        while ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = k;
        link_busy = busy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(k, busy);
        @(negedge clk);
    endtask

    // mostly polls with the link usually free, so refreshes run to the end
    task automatic send_random(input int busy_pct);
        int    r;
        kind_t k;
        r = $urandom_range(0, 99);
        if (r < 10)
            k = KIND_REQUEST;
        else if (r < 12)
            k = KIND_FORCE;
        else if (r < 14)
            k = KIND_NONE;
        else
            k = KIND_POLL;
        send_item(k, $urandom_range(0, 99) < busy_pct);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.count() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [WAIT_W-1:0] v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_limit(v);
        n_settings++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        logic [WAIT_W-1:0] limits[4];
        int                busy_pcts[4];
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_POLL;
        link_busy   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_go     = 1'b0;
        quiet       = 0;
        n_settings  = 1;
        in_gap_pct  = 14;
        out_gap_pct = 61;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset limit: idle poll, unused kind, start, queued request, first page
        send_item(KIND_POLL, 1'b0);
        send_item(KIND_NONE, 1'b0);
        send_item(KIND_REQUEST, 1'b0);
        send_item(KIND_REQUEST, 1'b1);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_POLL, 1'b0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_POLL, 1'b0);
        send_item(KIND_FORCE, 1'b1);

        // short limit: prepare timeout, then transfer timeout
        write_limit(10'd2);
        send_item(KIND_REQUEST, 1'b0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_REQUEST, 1'b0);
        send_item(KIND_POLL, 1'b0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_REQUEST, 1'b0);
        send_item(KIND_REQUEST, 1'b0);
        send_item(KIND_POLL, 1'b0);

        // zero limit: first busy poll aborts, pending request takes over
        write_limit(10'd0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_POLL, 1'b0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_FORCE, 1'b0);
        send_item(KIND_POLL, 1'b1);
        send_item(KIND_NONE, 1'b1);

        limits[0]    = 10'd1023;
        limits[1]    = 10'd1;
        limits[2]    = WAIT_W'($urandom_range(2, 6));
        limits[3]    = WAIT_W'($urandom_range(7, 40));
        busy_pcts[0] = 20;
        busy_pcts[1] = 10;
        busy_pcts[2] = 30;
        busy_pcts[3] = 45;
        for (int p = 0; p < 4; p++)
        begin
            write_limit(limits[p]);
            if (p == 1) begin
                in_gap_pct  = 61;
                out_gap_pct = 14;
            end else if (p == 2) begin
                in_gap_pct  = 0;
                out_gap_pct = 0;
                hold_go     = 1'b1;
            end
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                // sender pause until everything is back
                if (p == 3 && i == RAND_ITEMS / 2)
                    wait_drained();
                send_random(busy_pcts[p]);
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        $display("covered %0d input beats and %0d result beats over %0d timeout settings",
                 sb.n_in, sb.n_out, n_settings);
        $display("full refreshes completed: %0d, timeouts: %0d", sb.n_refreshes,
                 sb.n_timeouts);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== display_page_refresh_sequencer_core.f =====
rtl/dprs_pkg.sv
rtl/display_page_refresh_sequencer_core.sv
test/tb_display_page_refresh_sequencer_core.sv
